[rtl/core/ots_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_pkg
// Shared types and codes for the one-shot timer table.
// ----------------------------------------------------------------------------
package ots_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int SLOT_W        = 6;
   localparam int CNT_W         = 4;
   localparam int TASK_W        = 8;
   localparam int TIME_W        = 32;

   localparam logic OP_SCHED = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   localparam logic [1:0] KIND_SCHED = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_PENDING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              op;
      logic [TASK_W-1:0] task_id;
      logic [TIME_W-1:0] delay_ms;
      logic [TIME_W-1:0] now_ms;
   } item_type;

   typedef struct packed {
      logic              valid;
      logic [CNT_W-1:0]  fire_cnt;
      logic              dup_hit;
      logic [SLOT_W-1:0] dup_idx;
      logic              free_hit;
      logic [SLOT_W-1:0] free_idx;
   } probe_type;

   typedef struct packed {
      logic              hit;
      logic [TASK_W-1:0] task_id;
      logic [SLOT_W-1:0] slot_idx;
   } fire_type;

   typedef struct packed {
      logic              wr;
      logic [SLOT_W-1:0] slot_idx;
   } commit_type;

endpackage

[rtl/core/ots_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_cell
// One timer slot; examines the passing probe and hands it to the next cell.
// ----------------------------------------------------------------------------
module ots_cell #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  ots_pkg::item_type   item,
   input  logic                advance,
   input  ots_pkg::commit_type commit,
   input  ots_pkg::probe_type  probe_in,
   output ots_pkg::probe_type  probe_out,
   output ots_pkg::fire_type   fire
);

   logic                       active_ff, active_in;
   logic [ots_pkg::TIME_W-1:0] start_ff;
   logic [ots_pkg::TIME_W-1:0] delay_ff;
   logic [ots_pkg::TASK_W-1:0] task_ff;
   ots_pkg::probe_type         probe_ff, probe_in_next;
   logic [ots_pkg::TIME_W-1:0] elapsed;
   logic                       expired;
   logic                       fire_hit;
   logic                       wr_here;

   assign elapsed  = item.now_ms - start_ff;
   assign expired  = elapsed >= delay_ff;
   assign fire_hit = probe_in.valid && (item.op == ots_pkg::OP_CHECK) && active_ff
                     && expired
                     && (probe_in.fire_cnt < ots_pkg::CNT_W'(ots_pkg::MAX_RESULTS));
   assign wr_here  = commit.wr && (commit.slot_idx == ots_pkg::SLOT_W'(IDX));

   always_comb begin
      fire = '0;
      if (fire_hit) begin
         fire.hit      = 1'b1;
         fire.task_id  = task_ff;
         fire.slot_idx = ots_pkg::SLOT_W'(IDX);
      end
   end

   always_comb begin
      probe_in_next = probe_in;
      if (probe_in.valid && (item.op == ots_pkg::OP_SCHED)) begin
         if (active_ff && (task_ff == item.task_id) && !probe_in.dup_hit) begin
            probe_in_next.dup_hit = 1'b1;
            probe_in_next.dup_idx = ots_pkg::SLOT_W'(IDX);
         end
         if (!active_ff && !probe_in.free_hit) begin
            probe_in_next.free_hit = 1'b1;
            probe_in_next.free_idx = ots_pkg::SLOT_W'(IDX);
         end
      end
      if (fire_hit) begin
         probe_in_next.fire_cnt = probe_in.fire_cnt + ots_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      active_in = active_ff;
      if (wr_here) begin
         active_in = 1'b1;
      end else if (fire_hit && advance) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         probe_ff  <= '0;
      end else begin
         active_ff <= active_in;
         if (advance) begin
            probe_ff <= probe_in_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here) begin
         start_ff <= item.now_ms;
         delay_ff <= item.delay_ms;
         task_ff  <= item.task_id;
      end
   end

   assign probe_out = probe_ff;

endmodule

[rtl/core/ots_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_ctrl
// Item intake, chain sequencing, result holding and the output register.
// ----------------------------------------------------------------------------
module ots_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  ots_pkg::item_type          req_item,
   input  ots_pkg::probe_type         tail,
   input  ots_pkg::fire_type          fire,
   output ots_pkg::item_type          item,
   output ots_pkg::probe_type         head,
   output logic                       advance,
   output ots_pkg::commit_type        commit,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [1:0]                 rsp_kind,
   output logic [1:0]                 rsp_status,
   output logic [ots_pkg::TASK_W-1:0] rsp_fired_id,
   output logic [ots_pkg::SLOT_W-1:0] rsp_slot_index,
   output logic                       rsp_last
);

   ots_pkg::state_type         state_ff, state_in;
   ots_pkg::item_type          item_ff;
   ots_pkg::probe_type         head_ff;
   ots_pkg::probe_type         summary_ff;
   logic                       held_valid_ff;
   ots_pkg::fire_type          held_ff;
   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_kind_ff, rsp_kind_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [ots_pkg::TASK_W-1:0] rsp_id_ff, rsp_id_in;
   logic [ots_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       out_free;
   logic                       accept;
   logic                       flush_held;
   logic                       finishing;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ots_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ots_pkg::ST_SCAN;
            end
         end
         ots_pkg::ST_SCAN: begin
            if (tail.valid) begin
               state_in = ots_pkg::ST_FINISH;
            end
         end
         ots_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = ots_pkg::ST_IDLE;
            end
         end
         default: state_in = ots_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = (state_ff == ots_pkg::ST_IDLE);
      accept      = req_tready && req_tvalid;
      advance     = !(fire.hit && held_valid_ff && !out_free);
      flush_held  = fire.hit && advance && held_valid_ff;
      finishing   = (state_ff == ots_pkg::ST_FINISH) && out_free;
      commit.wr   = finishing && (item_ff.op == ots_pkg::OP_SCHED)
                    && !summary_ff.dup_hit && summary_ff.free_hit;
      commit.slot_idx = summary_ff.free_idx;

      rsp_kind_in   = ots_pkg::KIND_FIRED;
      rsp_status_in = ots_pkg::STATUS_OK;
      rsp_id_in     = held_ff.task_id;
      rsp_slot_in   = held_ff.slot_idx;
      rsp_last_in   = finishing;
      if (finishing) begin
         if (item_ff.op == ots_pkg::OP_SCHED) begin
            rsp_kind_in = ots_pkg::KIND_SCHED;
            rsp_id_in   = '0;
            if (summary_ff.dup_hit) begin
               rsp_status_in = ots_pkg::STATUS_PENDING;
               rsp_slot_in   = summary_ff.dup_idx;
            end else if (summary_ff.free_hit) begin
               rsp_status_in = ots_pkg::STATUS_OK;
               rsp_slot_in   = summary_ff.free_idx;
            end else begin
               rsp_status_in = ots_pkg::STATUS_FULL;
               rsp_slot_in   = '0;
            end
         end else if (!held_valid_ff) begin
            rsp_kind_in = ots_pkg::KIND_NONE;
            rsp_id_in   = '0;
            rsp_slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ots_pkg::ST_IDLE;
         head_ff       <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            head_ff.valid <= 1'b1;
         end else if (advance) begin
            head_ff.valid <= 1'b0;
         end
         if (fire.hit && advance) begin
            held_valid_ff <= 1'b1;
         end else if (finishing) begin
            held_valid_ff <= 1'b0;
         end
         if (flush_held || finishing) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (tail.valid && (state_ff == ots_pkg::ST_SCAN)) begin
         summary_ff <= tail;
      end
      if (fire.hit && advance) begin
         held_ff <= fire;
      end
      if (flush_held || finishing) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign item           = item_ff;
   assign head           = head_ff;
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fired_id   = rsp_id_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

[rtl/core/one_shot_timer_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_table
// Table of one-shot timers built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Each request beat is either a schedule or a check. A token walks the row of
// SLOTS cells one cell per cycle, except while a fired slot must wait because
// the output register still holds an untaken beat. The final response beat
// of an item is registered once the token has left the last cell.
// A schedule gives one response beat; a check gives one beat per fired slot
// in slot order (at most eight) or a single "none" beat, with tlast on the
// final beat. A new request is taken once the previous item has handed its
// final beat to the output register.
// ----------------------------------------------------------------------------
module one_shot_timer_table #(
   parameter int SLOTS = ots_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // task_id[7:0], delay_ms[39:8], now_ms[71:40]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], fired_id[9:2], slot_index[15:10]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);

   ots_pkg::item_type   req_item;
   ots_pkg::item_type   item;
   ots_pkg::commit_type commit;
   ots_pkg::probe_type  probe [SLOTS+1];
   ots_pkg::fire_type   fires [SLOTS];
   ots_pkg::fire_type   fire_any;
   logic                advance;
   logic [1:0]          rsp_kind;
   logic [1:0]          rsp_status;
   logic [7:0]          rsp_fired_id;
   logic [5:0]          rsp_slot_index;

   assign req_item.op       = req_tuser[0];
   assign req_item.task_id  = req_tdata[7:0];
   assign req_item.delay_ms = req_tdata[39:8];
   assign req_item.now_ms   = req_tdata[71:40];

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ots_cell #(
         .IDX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .item     (item),
         .advance  (advance),
         .commit   (commit),
         .probe_in (probe[i]),
         .probe_out(probe[i+1]),
         .fire     (fires[i])
      );
   end

   always_comb begin
      fire_any = '0;
      for (int i = 0; i < SLOTS; i++) begin
         fire_any.hit      = fire_any.hit | fires[i].hit;
         fire_any.task_id  = fire_any.task_id | fires[i].task_id;
         fire_any.slot_idx = fire_any.slot_idx | fires[i].slot_idx;
      end
   end

   ots_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_item      (req_item),
      .tail          (probe[SLOTS]),
      .fire          (fire_any),
      .item          (item),
      .head          (probe[0]),
      .advance       (advance),
      .commit        (commit),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_fired_id  (rsp_fired_id),
      .rsp_slot_index(rsp_slot_index),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {rsp_slot_index, rsp_fired_id, rsp_status};
   assign rsp_tuser = rsp_kind;

endmodule

[rtl/core/ots_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ots_checker
// Port-level checks for the one-shot timer table.
// ----------------------------------------------------------------------------
module ots_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ots_pkg::KIND_FIRED) |-> rsp_tlast)
      else $error("schedule or none beat without tlast");

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ots_pkg::KIND_NONE) |-> (rsp_tdata == 16'd0))
      else $error("none beat carries data");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while an item is in progress");

endmodule

bind one_shot_timer_table ots_checker u_ots_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the one-shot timer table.
// ----------------------------------------------------------------------------
// Request beats carry schedule and check items. A small timer-table model
// inside a scoreboard class works out the response beats that each accepted
// request should produce. Every response beat is compared field by field
// with the oldest outstanding beat. A directed opening covers duplicate
// tasks, a full table, zero and maximum intervals, time wrap and a check
// that fires every slot. Random items follow in four phases: no back-pressure,
// sender idles, receiver stalls, then both.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int TB_SLOTS = ots_pkg::SLOTS_DEFAULT;

   typedef struct {
      logic [1:0] kind;
      logic [1:0] status;
      logic [7:0] fired_id;
      logic [5:0] slot_index;
      logic       last;
   } rsp_beat_type;

   class expiry_board;
      bit                         armed[TB_SLOTS];
      logic [ots_pkg::TIME_W-1:0] start_of[TB_SLOTS];
      logic [ots_pkg::TIME_W-1:0] interval_of[TB_SLOTS];
      logic [ots_pkg::TASK_W-1:0] task_of[TB_SLOTS];
      rsp_beat_type               expected_beats[$];
      int                         mismatches;

      function new();
         for (int i = 0; i < TB_SLOTS; i++) begin
            armed[i] = 1'b0;
         end
         mismatches = 0;
      endfunction

      function int outstanding();
         return expected_beats.size();
      endfunction

      function void push_beat(logic [1:0] kind, logic [1:0] status, logic [7:0] fired,
                              int slot, logic last);
         rsp_beat_type beat;
         beat.kind       = kind;
         beat.status     = status;
         beat.fired_id   = fired;
         beat.slot_index = slot[5:0];
         beat.last       = last;
         expected_beats.push_back(beat);
      endfunction

      function void predict_item(ots_pkg::item_type it);
         logic [ots_pkg::TIME_W-1:0] elapsed;
         int                         fired;
         bit                         done;
         done  = 1'b0;
         fired = 0;
         if (it.op == ots_pkg::OP_SCHED) begin
            for (int i = 0; i < TB_SLOTS; i++) begin
               if (!done && armed[i] && task_of[i] == it.task_id) begin
                  push_beat(ots_pkg::KIND_SCHED, ots_pkg::STATUS_PENDING, 8'd0, i, 1'b1);
                  done = 1'b1;
               end
            end
            for (int i = 0; i < TB_SLOTS; i++) begin
               if (!done && !armed[i]) begin
                  armed[i]       = 1'b1;
                  start_of[i]    = it.now_ms;
                  interval_of[i] = it.delay_ms;
                  task_of[i]     = it.task_id;
                  push_beat(ots_pkg::KIND_SCHED, ots_pkg::STATUS_OK, 8'd0, i, 1'b1);
                  done = 1'b1;
               end
            end
            if (!done) begin
               push_beat(ots_pkg::KIND_SCHED, ots_pkg::STATUS_FULL, 8'd0, 0, 1'b1);
            end
         end else begin
            for (int i = 0; i < TB_SLOTS; i++) begin
               elapsed = it.now_ms - start_of[i];
               if (fired < ots_pkg::MAX_RESULTS && armed[i]
                   && elapsed >= interval_of[i]) begin
                  armed[i] = 1'b0;
                  push_beat(ots_pkg::KIND_FIRED, ots_pkg::STATUS_OK, task_of[i], i, 1'b0);
                  fired++;
               end
            end
            if (fired == 0) begin
               push_beat(ots_pkg::KIND_NONE, ots_pkg::STATUS_OK, 8'd0, 0, 1'b1);
            end else begin
               expected_beats[expected_beats.size() - 1].last = 1'b1;
            end
         end
      endfunction

      task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
         $display("%0t ns: response %s is %0h, expected %0h", $time, what, got, want);
         mismatches++;
      endtask

      task check_response(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t ns: response beat arrived with none outstanding", $time);
            mismatches++;
         end else begin
            want = expected_beats.pop_front();
            if (got.kind !== want.kind) begin
               report_mismatch("kind", got.kind, want.kind);
            end
            if (got.status !== want.status) begin
               report_mismatch("status", got.status, want.status);
            end
            if (got.fired_id !== want.fired_id) begin
               report_mismatch("fired_id", got.fired_id, want.fired_id);
            end
            if (got.slot_index !== want.slot_index) begin
               report_mismatch("slot_index", got.slot_index, want.slot_index);
            end
            if (got.last !== want.last) begin
               report_mismatch("last", got.last, want.last);
            end
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // task_id[7:0], delay_ms[39:8], now_ms[71:40]
   logic [0:0]  req_tuser = '0;   // op[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // status[1:0], fired_id[9:2], slot_index[15:10]
   logic [1:0]  rsp_tuser;        // kind[1:0]
   logic        rsp_tlast;

   expiry_board                board;
   int                         send_idle_pct = 0;
   int                         recv_stall_pct = 0;
   logic [ots_pkg::TIME_W-1:0] now_t;

   one_shot_timer_table #(
      .SLOTS(TB_SLOTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind       = rsp_tuser;
         got.status     = rsp_tdata[1:0];
         got.fired_id   = rsp_tdata[9:2];
         got.slot_index = rsp_tdata[15:10];
         got.last       = rsp_tlast;
         board.check_response(got);
      end
   end

   task automatic send_item(ots_pkg::item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.now_ms, it.delay_ms, it.task_id};
      req_tuser  <= it.op;
      do @(posedge clock); while (!req_tready);
      board.predict_item(it);
   endtask

   task automatic send_fields(logic op, logic [7:0] id, logic [31:0] delay, logic [31:0] now);
      ots_pkg::item_type it;
      it.op       = op;
      it.task_id  = id;
      it.delay_ms = delay;
      it.now_ms   = now;
      send_item(it);
   endtask

   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   function automatic ots_pkg::item_type random_item();
      ots_pkg::item_type it;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         now_t = $urandom;
      end else begin
         now_t = now_t + $urandom_range(0, 150);
      end
      it.now_ms = now_t;
      if ($urandom_range(0, 99) < 60) begin
         it.op      = ots_pkg::OP_SCHED;
         it.task_id = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 11))
                                                   : 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            it.delay_ms = '0;
         end else if (pick < 14) begin
            it.delay_ms = $urandom;
         end else if (pick < 16) begin
            it.delay_ms = '1;
         end else begin
            it.delay_ms = $urandom_range(1, 200);
         end
      end else begin
         it.op       = ots_pkg::OP_CHECK;
         it.task_id  = 8'($urandom_range(0, 255));
         it.delay_ms = $urandom;
      end
      return it;
   endfunction

   task automatic run_phase(int idle_pct, int stall_pct, int count);
      wait_for_quiet();
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         send_item(random_item());
      end
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_fields(ots_pkg::OP_CHECK, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_fields(ots_pkg::OP_SCHED, 8'h00, 32'h0000_0000, 32'h0000_0000);
      send_fields(ots_pkg::OP_SCHED, 8'h00, 32'h0000_0005, 32'h0000_0001);
      send_fields(ots_pkg::OP_SCHED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(ots_pkg::OP_SCHED, 8'h01, 32'd100, 32'hFFFF_FFF0);
      send_fields(ots_pkg::OP_CHECK, 8'h00, 32'h0000_0000, 32'h0000_0010);
      send_fields(ots_pkg::OP_CHECK, 8'h5A, 32'hA5A5_A5A5, 32'h0000_0053);
      send_fields(ots_pkg::OP_CHECK, 8'h00, 32'h0000_0000, 32'h0000_0054);
      for (int id = 2; id <= 8; id++) begin
         send_fields(ots_pkg::OP_SCHED, 8'(id), 32'd5, 32'h0000_0100);
      end
      send_fields(ots_pkg::OP_SCHED, 8'h09, 32'd5, 32'h0000_0100);
      send_fields(ots_pkg::OP_SCHED, 8'hFF, 32'd5, 32'h0000_0100);
      send_fields(ots_pkg::OP_CHECK, 8'h00, 32'h0000_0000, 32'hFFFF_FFFE);

      now_t = 32'hFFFF_FF00;
      run_phase(0, 0, 33);
      run_phase(70, 0, 33);
      run_phase(0, 70, 33);
      run_phase(28, 28, 33);

      wait_for_quiet();
      repeat (4 * TB_SLOTS) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
rtl/core/ots_pkg.sv
rtl/core/ots_cell.sv
rtl/core/ots_ctrl.sv
rtl/core/one_shot_timer_table.sv
rtl/core/ots_checker.sv
tb/tb_top.sv
